// ===== sv/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Concurrent assertion helpers. They expect clk and rst_n in the using scope
// and compile to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== sv/gamq_pkg.sv =====
// ============================================================================
// gamq_pkg
// Shared widths, codes, types and helpers of the gain-adaptive quantizer.
// ============================================================================
package gamq_pkg;

  localparam int COEF_W         = 24;
  localparam int MW_W           = 5;
  localparam int GS_W           = 2;
  localparam int CODE_W         = 16;
  localparam int FRAC_BITS      = 22;
  localparam int MAX_MANT_WIDTH = 16;
  localparam int MIN_MANT_WIDTH = 3;

  localparam int MAG_W    = COEF_W;                        // |coef|, up to 2^23
  localparam int OP_W     = COEF_W + 2;                    // 4|coef|
  localparam int PROD_W   = OP_W + MAX_MANT_WIDTH;
  localparam int SH_W     = MAG_W + MAX_MANT_WIDTH - 1;
  localparam int SMAG_W   = MAX_MANT_WIDTH + 1;
  localparam int KQ_W     = 19;
  localparam int THIRD_SH = 20;
  localparam int THIRD_RCP = (1 << THIRD_SH) / 3;
  localparam int THIRD_W  = KQ_W + THIRD_SH;
  localparam int QUO_W    = FRAC_BITS + 1;
  localparam int DIV_W    = MAX_MANT_WIDTH;
  localparam int NUM_W    = DIV_W + QUO_W - 1;

  localparam logic [GS_W-1:0] GSEL_X1   = 2'd0;
  localparam logic [GS_W-1:0] GSEL_X2   = 2'd1;
  localparam logic [GS_W-1:0] GSEL_X4   = 2'd2;
  localparam logic [GS_W-1:0] GSEL_RSVD = 2'd3;

  typedef enum logic [1:0] {
    MODE_G1,
    MODE_G2,
    MODE_G4
  } mode_t;

  typedef struct packed {
    logic             neg;
    logic [MW_W-1:0]  m;
    mode_t            mode;
  } ctl_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] nq;
    logic [DIV_W-1:0] dsr;
  } div_t;

  typedef struct packed {
    logic              neg;
    logic [CODE_W-1:0] main_code;
    logic [MW_W-1:0]   main_width;
    logic [CODE_W-1:0] esc_code;
    logic [MW_W-1:0]   esc_width;
  } side_t;

  // 2^bits - 1
  function automatic logic [CODE_W-1:0] width_mask(input logic [MW_W-1:0] bits);
    logic [CODE_W:0] one_hot;
    one_hot = (CODE_W+1)'(1) << bits;
    return CODE_W'(one_hot - (CODE_W+1)'(1));
  endfunction

endpackage

// ===== sv/gamq_front.sv =====
// ============================================================================
// gamq_front
// Six-stage front end: decode, scale multiply, rounding, divide by three,
// clamp and code build. Emits the reconstruction dividend and divisor.
// ============================================================================
module gamq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               req_vld,
  input  logic signed [gamq_pkg::COEF_W-1:0] coef_value,
  input  logic [gamq_pkg::MW_W-1:0]          mant_width,
  input  logic [gamq_pkg::GS_W-1:0]          gain_select,
  output logic                               div_vld,
  output gamq_pkg::div_t                     div_req,
  output gamq_pkg::side_t                    div_side
);

  localparam int STAGES = 6;
  localparam int MW_W   = gamq_pkg::MW_W;
  localparam int MAG_W  = gamq_pkg::MAG_W;
  localparam int OP_W   = gamq_pkg::OP_W;
  localparam int PROD_W = gamq_pkg::PROD_W;
  localparam int SH_W   = gamq_pkg::SH_W;
  localparam int SMAG_W = gamq_pkg::SMAG_W;
  localparam int KQ_W   = gamq_pkg::KQ_W;
  localparam int CODE_W = gamq_pkg::CODE_W;
  localparam int NUM_W  = gamq_pkg::NUM_W;
  localparam int DIV_W  = gamq_pkg::DIV_W;
  localparam int QUO_W  = gamq_pkg::QUO_W;
  localparam int FB     = gamq_pkg::FRAC_BITS;

  logic [STAGES-1:0] vld_r;

  // stage 1: sign, magnitude, width clamp, mode
  gamq_pkg::ctl_t    s1_ctl_r, s1_ctl_nxt;
  logic [MAG_W-1:0]  s1_mag_r, s1_mag_nxt;
  logic [MAG_W-1:0]  coef_bits;

  assign coef_bits = coef_value;

  always_comb begin
    s1_ctl_nxt.neg = coef_bits[MAG_W-1];
    s1_mag_nxt     = s1_ctl_nxt.neg ? (~coef_bits) + MAG_W'(1) : coef_bits;
    priority if (mant_width < MW_W'(gamq_pkg::MIN_MANT_WIDTH)) begin
      s1_ctl_nxt.m = MW_W'(gamq_pkg::MIN_MANT_WIDTH);
    end else if (mant_width > MW_W'(gamq_pkg::MAX_MANT_WIDTH)) begin
      s1_ctl_nxt.m = MW_W'(gamq_pkg::MAX_MANT_WIDTH);
    end else begin
      s1_ctl_nxt.m = mant_width;
    end
    unique case (gain_select)
      gamq_pkg::GSEL_X2:                    s1_ctl_nxt.mode = gamq_pkg::MODE_G2;
      gamq_pkg::GSEL_X4:                    s1_ctl_nxt.mode = gamq_pkg::MODE_G4;
      gamq_pkg::GSEL_X1, gamq_pkg::GSEL_RSVD: s1_ctl_nxt.mode = gamq_pkg::MODE_G1;
    endcase
  end

  // stage 2: scale multiply, small-quantizer magnitude
  gamq_pkg::ctl_t     s2_ctl_r;
  logic [PROD_W-1:0]  s2_prod_r, s2_prod_nxt;
  logic [SMAG_W-1:0]  s2_smag_r, s2_smag_nxt;
  logic [OP_W-1:0]    s2_two_a, s2_four_a, s2_op;
  logic [OP_W-1:0]    one_op;
  logic [MW_W-1:0]    s2_j;
  logic [DIV_W-1:0]   s2_dmul;
  logic [SH_W-1:0]    s2_shift;

  assign one_op = OP_W'(1) << FB;

  always_comb begin
    s2_two_a  = OP_W'({s1_mag_r, 1'b0});
    s2_four_a = {s1_mag_r, 2'b00};
    unique case (s1_ctl_r.mode)
      gamq_pkg::MODE_G1: begin
        s2_op = OP_W'(s1_mag_r);
        s2_j  = s1_ctl_r.m;
      end
      gamq_pkg::MODE_G2: begin
        s2_op = (s2_two_a >= one_op) ? s2_two_a - one_op : '0;
        s2_j  = s1_ctl_r.m - MW_W'(1);
      end
      gamq_pkg::MODE_G4: begin
        s2_op = (s2_four_a >= one_op) ? s2_four_a - one_op : '0;
        s2_j  = s1_ctl_r.m;
      end
      default: begin
        s2_op = '0;
        s2_j  = s1_ctl_r.m;
      end
    endcase
    s2_dmul     = gamq_pkg::width_mask(s2_j);
    s2_prod_nxt = {{DIV_W{1'b0}}, s2_op} * {{OP_W{1'b0}}, s2_dmul};
    s2_shift    = SH_W'(s1_mag_r) << (s1_ctl_r.m - MW_W'(1));
    s2_smag_nxt = SMAG_W'((s2_shift + SH_W'(1 << (FB - 1))) >> FB);
  end

  // stage 3: round the product, small-range check
  gamq_pkg::ctl_t     s3_ctl_r;
  logic [KQ_W-1:0]    s3_q_r, s3_q_nxt;
  logic [SMAG_W-1:0]  s3_smag_r;
  logic               s3_small_r, s3_small_nxt;
  logic [PROD_W:0]    s3_rnd;
  logic [SMAG_W-1:0]  s3_half;

  always_comb begin
    if (s2_ctl_r.mode == gamq_pkg::MODE_G4) begin
      s3_rnd  = {1'b0, s2_prod_r} + (PROD_W+1)'(3 << FB);
      s3_half = SMAG_W'(1) << (s2_ctl_r.m - MW_W'(3));
    end else begin
      s3_rnd  = {1'b0, s2_prod_r} + (PROD_W+1)'(1 << FB);
      s3_half = SMAG_W'(1) << (s2_ctl_r.m - MW_W'(2));
    end
    s3_q_nxt     = KQ_W'(s3_rnd >> (FB + 1));
    s3_small_nxt = s2_smag_r < s3_half;
  end

  // stage 4: reciprocal multiply for the divide by three
  gamq_pkg::ctl_t                  s4_ctl_r;
  logic [gamq_pkg::THIRD_W-1:0]    s4_third_r, s4_third_nxt;
  logic [KQ_W-1:0]                 s4_q_r;
  logic [SMAG_W-1:0]               s4_smag_r;
  logic                            s4_small_r;

  assign s4_third_nxt = {{gamq_pkg::THIRD_SH{1'b0}}, s3_q_r}
                      * gamq_pkg::THIRD_W'(gamq_pkg::THIRD_RCP);

  // stage 5: quotient correction
  gamq_pkg::ctl_t     s5_ctl_r;
  logic [KQ_W-1:0]    s5_k_r, s5_k_nxt;
  logic [SMAG_W-1:0]  s5_smag_r;
  logic               s5_small_r;
  logic [KQ_W-1:0]    s5_qe, s5_rem;

  always_comb begin
    s5_qe  = KQ_W'(s4_third_r >> gamq_pkg::THIRD_SH);
    s5_rem = s4_q_r - (KQ_W'(s5_qe << 1) + s5_qe);
    if (s4_ctl_r.mode == gamq_pkg::MODE_G4) begin
      s5_k_nxt = (s5_rem >= KQ_W'(3)) ? s5_qe + KQ_W'(1) : s5_qe;
    end else begin
      s5_k_nxt = s4_q_r;
    end
  end

  // stage 6: clamp, codes, reconstruction dividend and divisor
  gamq_pkg::div_t     div_r, div_nxt;
  gamq_pkg::side_t    side_r, side_nxt;
  logic               s6_is_g4;
  logic [MW_W-1:0]    s6_sb, s6_eb;
  logic [CODE_W-1:0]  s6_lim, s6_kc, s6_kneg, s6_smag, s6_sneg;
  logic [DIV_W-1:0]   s6_dsr;
  logic [NUM_W-1:0]   s6_num;

  always_comb begin
    s6_is_g4 = (s5_ctl_r.mode == gamq_pkg::MODE_G4);
    s6_sb    = s6_is_g4 ? s5_ctl_r.m - MW_W'(2) : s5_ctl_r.m - MW_W'(1);
    s6_eb    = s6_is_g4 ? s5_ctl_r.m : s5_ctl_r.m - MW_W'(1);
    s6_lim   = (s5_ctl_r.mode == gamq_pkg::MODE_G1)
             ? gamq_pkg::width_mask(s5_ctl_r.m - MW_W'(1))
             : gamq_pkg::width_mask(s6_eb - MW_W'(1));
    s6_kc    = (s5_k_r > KQ_W'(s6_lim)) ? s6_lim : CODE_W'(s5_k_r);
    s6_kneg  = ~s6_kc + CODE_W'(1);
    s6_smag  = CODE_W'(s5_smag_r);
    s6_sneg  = ~s6_smag + CODE_W'(1);
    side_nxt     = '0;
    side_nxt.neg = s5_ctl_r.neg;
    s6_dsr       = DIV_W'(1);
    s6_num       = '0;
    unique case (s5_ctl_r.mode)
      gamq_pkg::MODE_G1: begin
        side_nxt.main_code  = (s5_ctl_r.neg ? s6_kneg : s6_kc)
                            & gamq_pkg::width_mask(s5_ctl_r.m);
        side_nxt.main_width = s5_ctl_r.m;
        s6_dsr = gamq_pkg::width_mask(s5_ctl_r.m);
        s6_num = (NUM_W'(s6_kc) << (FB + 1)) + NUM_W'(s6_dsr >> 1);
      end
      gamq_pkg::MODE_G2, gamq_pkg::MODE_G4: begin
        side_nxt.main_width = s6_sb;
        if (s5_small_r) begin
          side_nxt.main_code = (s5_ctl_r.neg ? s6_sneg : s6_smag)
                             & gamq_pkg::width_mask(s6_sb);
          s6_dsr = DIV_W'(1);
          s6_num = NUM_W'(s6_smag) << (MW_W'(QUO_W) - s5_ctl_r.m);
        end else begin
          side_nxt.main_code = CODE_W'(1) << (s6_sb - MW_W'(1));
          side_nxt.esc_code  = (s5_ctl_r.neg ? ~s6_kc : s6_kc)
                             & gamq_pkg::width_mask(s6_eb);
          side_nxt.esc_width = s6_eb;
          s6_dsr = gamq_pkg::width_mask(s6_eb);
          if (s6_is_g4) begin
            s6_num = (NUM_W'(s6_kc) << FB) + (NUM_W'(s6_kc) << (FB - 1))
                   + NUM_W'(s6_dsr >> 1) + (NUM_W'(s6_dsr) << (FB - 2));
          end else begin
            s6_num = (NUM_W'(s6_kc) << FB)
                   + NUM_W'(s6_dsr >> 1) + (NUM_W'(s6_dsr) << (FB - 1));
          end
        end
      end
      default: begin
        side_nxt.main_width = s5_ctl_r.m;
      end
    endcase
    div_nxt.rem = DIV_W'(s6_num >> QUO_W);
    div_nxt.nq  = s6_num[QUO_W-1:0];
    div_nxt.dsr = s6_dsr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], req_vld};
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r   <= s1_ctl_nxt;
    s1_mag_r   <= s1_mag_nxt;
    s2_ctl_r   <= s1_ctl_r;
    s2_prod_r  <= s2_prod_nxt;
    s2_smag_r  <= s2_smag_nxt;
    s3_ctl_r   <= s2_ctl_r;
    s3_q_r     <= s3_q_nxt;
    s3_smag_r  <= s2_smag_r;
    s3_small_r <= s3_small_nxt;
    s4_ctl_r   <= s3_ctl_r;
    s4_third_r <= s4_third_nxt;
    s4_q_r     <= s3_q_r;
    s4_smag_r  <= s3_smag_r;
    s4_small_r <= s3_small_r;
    s5_ctl_r   <= s4_ctl_r;
    s5_k_r     <= s5_k_nxt;
    s5_smag_r  <= s4_smag_r;
    s5_small_r <= s4_small_r;
    div_r      <= div_nxt;
    side_r     <= side_nxt;
  end

  assign div_vld  = vld_r[STAGES-1];
  assign div_req  = div_r;
  assign div_side = side_r;

endmodule

// ===== sv/gamq_div.sv =====
// ============================================================================
// gamq_div
// Pipelined restoring divider, one quotient bit per stage, with the item's
// code fields riding alongside.
// ============================================================================
module gamq_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  gamq_pkg::div_t                    in_req,
  input  gamq_pkg::side_t                   in_side,
  output logic                              out_vld,
  output logic [gamq_pkg::QUO_W-1:0]        out_quo,
  output gamq_pkg::side_t                   out_side
);

  localparam int QUO_W = gamq_pkg::QUO_W;
  localparam int DIV_W = gamq_pkg::DIV_W;

  logic [QUO_W-1:0] vld_r;
  gamq_pkg::div_t   stg_r   [QUO_W];
  gamq_pkg::div_t   stg_nxt [QUO_W];
  gamq_pkg::side_t  side_r  [QUO_W];

  for (genvar gi = 0; gi < QUO_W; gi++) begin : g_stage
    gamq_pkg::div_t   src;
    logic [DIV_W:0]   trial;
    logic             take;

    if (gi == 0) begin : g_first
      assign src = in_req;
    end else begin : g_rest
      assign src = stg_r[gi-1];
    end

    assign trial = {src.rem, src.nq[QUO_W-1]};
    assign take  = trial >= {1'b0, src.dsr};
    assign stg_nxt[gi].rem = take ? DIV_W'(trial - {1'b0, src.dsr}) : DIV_W'(trial);
    assign stg_nxt[gi].nq  = {src.nq[QUO_W-2:0], take};
    assign stg_nxt[gi].dsr = src.dsr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QUO_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int i = 0; i < QUO_W; i++) begin
      stg_r[i] <= stg_nxt[i];
    end
    for (int i = 1; i < QUO_W; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = stg_r[QUO_W-1].nq;
  assign out_side = side_r[QUO_W-1];

endmodule

// ===== sv/gain_adaptive_mantissa_quantizer_top.sv =====
// ============================================================================
// gain_adaptive_mantissa_quantizer_top
// Quantizes one Q2.22 coefficient per request under a mantissa width and a
// gain of 1, 2 or 4, with tag plus escape codeword on small-quantizer overflow.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is high only while rst_n is low; otherwise a request can be taken
//   at every clock.
//   Each request yields exactly one result, in request order. out_valid goes
//   high once the request has passed the registers listed below, and the
//   result is taken at a rising edge where out_valid is high.
//   Throughput is one request per cycle: 6 front stages (decode, multiply,
//   round, divide by three over two stages, code build), 23 divider stages
//   producing one reconstruction bit each, and one output register.
//   The receiver cannot stall; results are not held.
//   Reset (synchronous, active low) drops every request in flight.
// ============================================================================
`include "assert_macros.svh"

module gain_adaptive_mantissa_quantizer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [gamq_pkg::COEF_W-1:0]  in_coef_value,
  input  logic [gamq_pkg::MW_W-1:0]           in_mant_width,
  input  logic [gamq_pkg::GS_W-1:0]           in_gain_select,
  output logic                                out_valid,
  output logic [gamq_pkg::CODE_W-1:0]         out_main_code,
  output logic [gamq_pkg::MW_W-1:0]           out_main_width,
  output logic [gamq_pkg::CODE_W-1:0]         out_escape_code,
  output logic [gamq_pkg::MW_W-1:0]           out_escape_width,
  output logic signed [gamq_pkg::COEF_W-1:0]  out_recon_value
);

  localparam int COEF_W = gamq_pkg::COEF_W;

  logic                          div_vld;
  gamq_pkg::div_t                div_req;
  gamq_pkg::side_t               div_side;
  logic                          quo_vld;
  logic [gamq_pkg::QUO_W-1:0]    quo;
  gamq_pkg::side_t               quo_side;

  logic                          out_vld_r;
  gamq_pkg::side_t               out_side_r;
  logic [COEF_W-1:0]             out_recon_r, out_recon_nxt;

  assign busy = ~rst_n;

  gamq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_vld     (start & ~busy),
    .coef_value  (in_coef_value),
    .mant_width  (in_mant_width),
    .gain_select (in_gain_select),
    .div_vld     (div_vld),
    .div_req     (div_req),
    .div_side    (div_side)
  );

  gamq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div_vld),
    .in_req   (div_req),
    .in_side  (div_side),
    .out_vld  (quo_vld),
    .out_quo  (quo),
    .out_side (quo_side)
  );

  assign out_recon_nxt = quo_side.neg ? (~{1'b0, quo}) + COEF_W'(1) : {1'b0, quo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_side_r  <= quo_side;
    out_recon_r <= out_recon_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_main_code    = out_side_r.main_code;
  assign out_main_width   = out_side_r.main_width;
  assign out_escape_code  = out_side_r.esc_code;
  assign out_escape_width = out_side_r.esc_width;
  assign out_recon_value  = out_recon_r;

  `ASSERT_IMPLY(a_esc_width_pair, out_valid && (out_escape_width != 5'd0), (out_escape_width == out_main_width) || (out_escape_width == out_main_width + 5'd2))
  `ASSERT_IMPLY(a_esc_unused_zero, out_valid && (out_escape_width == 5'd0), out_escape_code == 16'd0)
  `ASSERT_IMPLY(a_tag_code, out_valid && (out_escape_width != 5'd0), out_main_code == (16'd1 << (out_main_width - 5'd1)))
  `ASSERT_IMPLY(a_main_fits, out_valid, (out_main_code >> out_main_width) == 16'd0)
  `ASSERT_NEVER(a_recon_range, out_valid && ((out_recon_value > 24'sd4194304) || (out_recon_value < -24'sd4194304)))

endmodule
